### rtl/plt_pkg.sv
// Types, codes and constants shared by the positional list table modules.
package plt_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_PRIOR  = 3'd3,
        KIND_NEXT   = 3'd4,
        KIND_CLEAR  = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BAD  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_CMP  = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        RD_INDEX = 2'd0,
        RD_PRIOR = 2'd1,
        RD_NEXT  = 2'd2
    } read_mode_t;

    typedef struct packed {
        cell_op_t   op;
        read_mode_t mode;
        logic       find_en;
    } ctrl_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_value;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  list_length;
    } out_t;

endpackage

### rtl/plt_cell.sv
// One list entry: holds a word, shifts with its neighbors and compares against a search value.
module plt_cell #(
    parameter int WORD_WIDTH = plt_pkg::WORD_WIDTH_DEFAULT,
    parameter int IDXW       = 6,
    parameter int CW         = 7
) (
    input  logic                  aclk,
    input  plt_pkg::cell_op_t     op,
    input  logic [IDXW-1:0]       cell_index,
    input  logic [CW-1:0]         count,
    input  logic [IDXW-1:0]       shift_index,
    input  logic [WORD_WIDTH-1:0] shift_word,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic [WORD_WIDTH-1:0] right_word,
    output logic [WORD_WIDTH-1:0] word,
    output logic                  hit,
    output logic                  valid
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  hit_reg;
    logic                  hit_next;

    assign valid = count > CW'(cell_index);

    always_comb begin
        word_next = word_reg;
        hit_next  = hit_reg;
        unique case (op)
            plt_pkg::CELL_HOLD: begin
                word_next = word_reg;
            end
            plt_pkg::CELL_INS: begin
                if (cell_index > shift_index) begin
                    word_next = left_word;
                end else if (cell_index == shift_index) begin
                    word_next = shift_word;
                end
            end
            plt_pkg::CELL_DEL: begin
                if (cell_index >= shift_index) begin
                    word_next = right_word;
                end
            end
            plt_pkg::CELL_CMP: begin
                hit_next = valid && (word_reg == shift_word);
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        hit_reg  <= hit_next;
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

### rtl/plt_cell_array.sv
// Row of list cells with first-match isolation and the selected-word readout.
module plt_cell_array #(
    parameter int DEPTH      = plt_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = plt_pkg::WORD_WIDTH_DEFAULT,
    parameter int IDXW       = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  plt_pkg::ctrl_t        ctrl,
    input  logic [CW-1:0]         count,
    input  logic [IDXW-1:0]       shift_index,
    input  logic [WORD_WIDTH-1:0] shift_word,
    output logic [WORD_WIDTH-1:0] sel_word,
    output logic                  sel_any
);

    wire  [WORD_WIDTH-1:0] word_w   [DEPTH];
    wire  [WORD_WIDTH-1:0] masked_w [DEPTH];
    wire  [DEPTH-1:0]      hit_vec;
    wire  [DEPTH-1:0]      valid_vec;
    wire  [DEPTH-1:0]      sel_vec;
    logic [DEPTH-1:0]      first_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_word;
        logic [WORD_WIDTH-1:0] right_word;
        logic                  prior_src;
        logic                  next_src;

        if (i == 0) begin : g_head
            assign left_word = '0;
            assign next_src  = 1'b0;
        end else begin : g_body
            assign left_word = word_w[i-1];
            assign next_src  = first_reg[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_word = '0;
            assign prior_src  = 1'b0;
        end else begin : g_inner
            assign right_word = word_w[i+1];
            assign prior_src  = first_reg[i+1];
        end

        plt_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .IDXW       (IDXW),
            .CW         (CW)
        ) u_cell (
            .aclk        (aclk),
            .op          (ctrl.op),
            .cell_index  (IDXW'(i)),
            .count       (count),
            .shift_index (shift_index),
            .shift_word  (shift_word),
            .left_word   (left_word),
            .right_word  (right_word),
            .word        (word_w[i]),
            .hit         (hit_vec[i]),
            .valid       (valid_vec[i])
        );

        assign sel_vec[i] =
            ((ctrl.mode == plt_pkg::RD_INDEX) && (IDXW'(i) == shift_index)) ||
            ((ctrl.mode == plt_pkg::RD_PRIOR) && prior_src && valid_vec[i]) ||
            ((ctrl.mode == plt_pkg::RD_NEXT) && next_src && valid_vec[i]);

        assign masked_w[i] = word_w[i] & {WORD_WIDTH{sel_vec[i]}};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.find_en) begin
            first_reg <= hit_vec & (~hit_vec + DEPTH'(1));
        end
    end

    always_comb begin
        sel_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_word = sel_word | masked_w[i];
        end
    end

    assign sel_any = |sel_vec;

endmodule

### rtl/positional_list_table_core.sv
// Positional list table: a packed list of words held in a row of shifting cells.
// Get, insert, delete and clear: the result is registered from the execute state.
// Prior and next: cell compare, first-match isolation and neighbor select, in that order.
// A new command is taken only when idle, after the last result is emitted; an untaken result stalls the next one.
// aresetn (synchronous, active low) empties the list and drops any pending result.
// Entry words are not cleared by reset.
module positional_list_table_core #(
    parameter int DEPTH      = plt_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = plt_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  plt_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output plt_pkg::out_t m_data
);

    localparam int IDXW   = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int POS_W  = plt_pkg::POS_W;
    localparam int DATA_W = plt_pkg::DATA_W;
    localparam int LEN_W  = plt_pkg::LEN_W;
    localparam int CMPW   = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_FIND = 4'b0100,
        ST_PICK = 4'b1000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    plt_pkg::out_t               m_data_reg;
    logic [plt_pkg::KIND_W-1:0]  kind_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [WORD_WIDTH-1:0]       val_reg;

    plt_pkg::ctrl_t              ctrl;
    plt_pkg::status_t            status;
    logic [WORD_WIDTH-1:0]       rd_word;
    logic [WORD_WIDTH-1:0]       sel_word;
    logic                        sel_any;
    logic                        emit;
    logic                        out_free;
    logic [POS_W-1:0]            pos_m1;
    logic [IDXW-1:0]             shift_index;
    logic [CMPW-1:0]             pos_ext;
    logic [CMPW-1:0]             cnt_ext;
    logic                        in_range;
    logic                        ins_range;
    logic                        is_full;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign pos_m1      = pos_reg - 1'b1;
    assign shift_index = IDXW'(pos_m1);
    assign pos_ext     = CMPW'(pos_reg);
    assign cnt_ext     = CMPW'(count_reg);
    assign in_range    = (pos_reg != '0) && (pos_ext <= cnt_ext);
    assign ins_range   = (pos_reg != '0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign is_full     = (count_reg == CW'(DEPTH));

    plt_cell_array #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .IDXW       (IDXW),
        .CW         (CW)
    ) u_array (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .count       (count_reg),
        .shift_index (shift_index),
        .shift_word  (val_reg),
        .sel_word    (sel_word),
        .sel_any     (sel_any)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ctrl.op      = plt_pkg::CELL_HOLD;
        ctrl.mode    = plt_pkg::RD_INDEX;
        ctrl.find_en = 1'b0;
        emit         = 1'b0;
        status       = plt_pkg::STATUS_BAD;
        rd_word      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if ((kind_reg == plt_pkg::KIND_PRIOR) || (kind_reg == plt_pkg::KIND_NEXT)) begin
                    ctrl.op    = plt_pkg::CELL_CMP;
                    state_next = ST_FIND;
                end else if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    unique case (kind_reg)
                        plt_pkg::KIND_GET: begin
                            if (in_range) begin
                                status  = plt_pkg::STATUS_OK;
                                rd_word = sel_word;
                            end
                        end
                        plt_pkg::KIND_INSERT: begin
                            if (ins_range) begin
                                if (is_full) begin
                                    status = plt_pkg::STATUS_FULL;
                                end else begin
                                    ctrl.op    = plt_pkg::CELL_INS;
                                    count_next = count_reg + 1'b1;
                                    status     = plt_pkg::STATUS_OK;
                                end
                            end
                        end
                        plt_pkg::KIND_DELETE: begin
                            if (in_range) begin
                                ctrl.op    = plt_pkg::CELL_DEL;
                                count_next = count_reg - 1'b1;
                                status     = plt_pkg::STATUS_OK;
                                rd_word    = sel_word;
                            end
                        end
                        plt_pkg::KIND_CLEAR: begin
                            count_next = '0;
                            status     = plt_pkg::STATUS_OK;
                        end
                        default: begin
                            status = plt_pkg::STATUS_BAD;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                ctrl.find_en = 1'b1;
                state_next   = ST_PICK;
            end
            ST_PICK: begin
                ctrl.mode = (kind_reg == plt_pkg::KIND_PRIOR) ? plt_pkg::RD_PRIOR
                                                               : plt_pkg::RD_NEXT;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (sel_any) begin
                        status  = plt_pkg::STATUS_OK;
                        rd_word = sel_word;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_data.kind;
            pos_reg  <= s_data.position;
            val_reg  <= WORD_WIDTH'(s_data.item_value);
        end
        if (emit) begin
            m_data_reg.status      <= status;
            m_data_reg.read_value  <= DATA_W'(rd_word);
            m_data_reg.list_length <= LEN_W'(count_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted command did not start execution");

    a_count_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !emit |=> (count_reg == $past(count_reg)))
        else $error("entry count changed without a result");

    a_shift_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((ctrl.op == plt_pkg::CELL_INS) || (ctrl.op == plt_pkg::CELL_DEL)) |-> emit)
        else $error("cells shifted without a result");
`endif

endmodule
